// ----- rtl/sssd_pkg.sv -----
// Shared constants, types and the glyph decoder for the seven-segment scan decoder.
package sssd_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int CHAR_COUNT  = 8;
	localparam int SCAN_W      = $clog2(DIGIT_COUNT);
	localparam int INDEX_W     = $clog2(CHAR_COUNT);

	localparam logic [SCAN_W-1:0] LAST_DIGIT = SCAN_W'(DIGIT_COUNT - 1);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register index is the word address, paddr[2]
	localparam logic REG_CATHODE_MODE = 1'b0;
	localparam logic CATHODE_MODE_RST = 1'b1;

	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_C     = 8'h63;
	localparam logic [7:0] CHAR_F     = 8'h66;
	localparam logic [7:0] CHAR_A     = 8'h61;
	localparam logic [7:0] CHAR_H     = 8'h68;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;

	typedef struct packed {
		logic [SCAN_W-1:0] scan;
		logic [SCAN_W-1:0] dots;
	} sssd_status_t;

	// Segments a..g in bits 0..6, lit = 1
	function automatic logic [6:0] glyph_of(input logic [7:0] ch);
		logic [6:0] g;
		g = 7'h00;
		case (ch) inside
			[CHAR_ZERO:CHAR_NINE]: begin
				case (ch[3:0])
					4'd0: g = 7'h3F;
					4'd1: g = 7'h06;
					4'd2: g = 7'h5B;
					4'd3: g = 7'h4F;
					4'd4: g = 7'h66;
					4'd5: g = 7'h6D;
					4'd6: g = 7'h7D;
					4'd7: g = 7'h07;
					4'd8: g = 7'h7F;
					4'd9: g = 7'h6F;
					default: g = 7'h00;
				endcase
			end
			CHAR_C:    g = 7'h39;
			CHAR_F:    g = 7'h71;
			CHAR_A:    g = 7'h77;
			CHAR_H:    g = 7'h76;
			CHAR_DASH: g = 7'h40;
			default:   g = 7'h00;
		endcase
		return g;
	endfunction

endpackage

// ----- rtl/sssd_if.sv -----
// Text input and drive output channel interfaces.
interface sssd_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_0;
	logic [7:0] char_1;
	logic [7:0] char_2;
	logic [7:0] char_3;
	logic [7:0] char_4;
	logic [7:0] char_5;
	logic [7:0] char_6;
	logic [7:0] char_7;

	modport source (
		output valid, char_0, char_1, char_2, char_3, char_4, char_5, char_6, char_7,
		input  ready
	);
	modport sink (
		input  valid, char_0, char_1, char_2, char_3, char_4, char_5, char_6, char_7,
		output ready
	);
endinterface

interface sssd_drive_if;
	logic       valid;
	logic       ready;
	logic [3:0] digit_drive;
	logic [7:0] segment_drive;
	logic [1:0] scan_digit;

	modport source (
		output valid, digit_drive, segment_drive, scan_digit,
		input  ready
	);
	modport sink (
		input  valid, digit_drive, segment_drive, scan_digit,
		output ready
	);
endinterface

// ----- rtl/sssd_apb_regs.sv -----
// APB register block holding the display polarity setting.
module sssd_apb_regs
	import sssd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic                  cathode_mode
);

	logic cc_q;
	logic wr_en;
	logic reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_CATHODE_MODE);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CATHODE_MODE_RST;
		end else if (wr_en && reg_sel) begin
			cc_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[0] = cc_q;
		end
	end

	assign cathode_mode = cc_q;

endmodule

// ----- rtl/sssd_scan.sv -----
// Scan position and dot tracking, glyph decode and the registered drive output.
module sssd_scan
	import sssd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cathode_mode,
	sssd_text_if.sink    text,
	sssd_drive_if.source drive,
	output sssd_status_t status
);

	logic [SCAN_W-1:0]      scan_q;
	logic [SCAN_W-1:0]      dots_q;
	logic                   valid_q;
	logic [DIGIT_COUNT-1:0] digit_q;
	logic [7:0]             seg_q;
	logic [SCAN_W-1:0]      pos_q;

	logic [7:0]             chars [CHAR_COUNT];
	logic [INDEX_W-1:0]     idx;
	logic [INDEX_W-1:0]     nxt;
	logic                   point;
	logic [7:0]             lit;
	logic [DIGIT_COUNT-1:0] en;
	logic                   accept;

	assign chars[0] = text.char_0;
	assign chars[1] = text.char_1;
	assign chars[2] = text.char_2;
	assign chars[3] = text.char_3;
	assign chars[4] = text.char_4;
	assign chars[5] = text.char_5;
	assign chars[6] = text.char_6;
	assign chars[7] = text.char_7;

	// Output register frees up when empty or drained this cycle
	assign text.ready = ~valid_q | drive.ready;
	assign accept     = text.valid & text.ready;

	always_comb begin
		idx   = INDEX_W'(scan_q) + INDEX_W'(dots_q);
		nxt   = idx + INDEX_W'(1);
		point = (chars[nxt] == CHAR_DOT);
		lit   = {point, glyph_of(chars[idx])};
		en    = DIGIT_COUNT'(1) << scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			dots_q <= '0;
		end else if (accept) begin
			if (scan_q == LAST_DIGIT) begin
				scan_q <= '0;
				dots_q <= '0;
			end else begin
				scan_q <= scan_q + SCAN_W'(1);
				// Skip the point character on later digits
				dots_q <= dots_q + SCAN_W'(point);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (text.ready) begin
			valid_q <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q   <= scan_q;
			digit_q <= cathode_mode ? en : ~en;
			seg_q   <= cathode_mode ? ~lit : lit;
		end
	end

	assign drive.valid         = valid_q;
	assign drive.digit_drive   = digit_q;
	assign drive.segment_drive = seg_q;
	assign drive.scan_digit    = pos_q;

	assign status.scan = scan_q;
	assign status.dots = dots_q;

endmodule

// ----- rtl/seven_segment_scan_decoder.sv -----
// Top level of the four-digit seven-segment scan decoder.
//
//   port    role    carries
//   text    sink    char_0..char_7, one eight-byte text per transfer
//   drive   source  digit_drive, segment_drive, scan_digit, one scan tick
//   apb     slave   cathode_mode at address 0
//
// One text transfer per clock while text.ready is high; each result enters the
// output register in the cycle after its transfer. text.ready stays high while
// the output register is empty or being drained, so a stalled drive channel
// holds one result and blocks new transfers only then. Reset clears scan
// position and dot count and sets cathode_mode to 1.
module seven_segment_scan_decoder
	import sssd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	sssd_text_if.sink             text,
	sssd_drive_if.source          drive,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic         cathode_mode;
	sssd_status_t status;

	sssd_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.cathode_mode (cathode_mode)
	);

	sssd_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.cathode_mode (cathode_mode),
		.text         (text),
		.drive        (drive),
		.status       (status)
	);

`ifndef ASSERT_OFF
	// At most one point consumed per digit already shown
	a_dots_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.dots <= status.scan)
		else $error("dot count ran ahead of scan position");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.ready) |=> drive.valid)
		else $error("accepted text produced no result");

	a_sweep_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.ready && status.scan == LAST_DIGIT)
		|=> (status.scan == '0 && status.dots == '0))
		else $error("scan did not wrap after last digit");
`endif

endmodule

// ----- tb/sssd_drive_checker.sv -----
// Scan tick predictor and drive channel checker for the seven-segment scan decoder.
module sssd_drive_checker
	import sssd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	sssd_text_if                  text,
	sssd_drive_if                 drive,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata,
	input  logic                  pready,
	output int                    pending,
	output int                    checked,
	output int                    failures
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [CHAR_COUNT-1:0][7:0] text_t;

	typedef struct packed {
		logic [3:0] digit;
		logic [7:0] segs;
		logic [1:0] scan;
	} drive_word_t;

	localparam logic [6:0] NUMERAL_SEGS [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	drive_word_t   expected_drives [$];
	logic [1:0]    scan_pos;
	logic [1:0]    dot_count;
	logic          cathode;
	int            errors;
	int            results;

	// Segments a..g lit for one character, blank when it has no glyph
	function automatic logic [6:0] segment_pattern(input logic [7:0] ch);
		logic [6:0] segs;
		segs = '0;
		if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
			segs = NUMERAL_SEGS[ch - CHAR_ZERO];
		end else begin
			case (ch)
				CHAR_C:    segs = 7'h39;
				CHAR_F:    segs = 7'h71;
				CHAR_A:    segs = 7'h77;
				CHAR_H:    segs = 7'h76;
				CHAR_DASH: segs = 7'h40;
				default:   segs = '0;
			endcase
		end
		return segs;
	endfunction

	function automatic drive_word_t scan_tick(input text_t t, input logic [1:0] scan,
			input logic [1:0] dots, input logic cc,
			output logic [1:0] scan_nx, output logic [1:0] dots_nx);
		logic [2:0]  shown;
		logic [2:0]  probe;
		logic        point;
		logic [7:0]  lit;
		logic [3:0]  enable;
		drive_word_t w;
		shown   = 3'(scan) + 3'(dots);
		probe   = shown + 3'd1;
		point   = (t[probe] == CHAR_DOT);
		lit     = {point, segment_pattern(t[shown])};
		enable  = 4'b0001 << scan;
		w.digit = cc ? enable : ~enable;
		w.segs  = cc ? ~lit : lit;
		w.scan  = scan;
		// last digit clears the sweep, otherwise a point skips the next byte
		if (scan == LAST_DIGIT) begin
			scan_nx = '0;
			dots_nx = '0;
		end else begin
			scan_nx = scan + 2'd1;
			dots_nx = dots + 2'(point);
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_word_t got;
		drive_word_t want;
		logic [1:0]  scan_nx;
		logic [1:0]  dots_nx;
		if (!arst_n) begin
			scan_pos  = '0;
			dot_count = '0;
			cathode   = CATHODE_MODE_RST;
			expected_drives.delete();
			pending  <= 0;
			checked  <= 0;
			failures <= errors;
		end else begin
			// retire the oldest tick before queuing the one accepted at this edge
			if (drive.valid && drive.ready) begin
				got = '{drive.digit_drive, drive.segment_drive, drive.scan_digit};
				results++;
				if (expected_drives.size() == 0) begin
					errors++;
					$display("%0t: drive transfer with nothing expected: %s",
						$time, "expected none");
					$display("%0t:   got digit %h seg %h scan %0d",
						$time, got.digit, got.segs, got.scan);
				end else begin
					want = expected_drives.pop_front();
					if (got.digit !== want.digit || got.segs !== want.segs ||
							got.scan !== want.scan) begin
						errors++;
						$display("%0t: drive mismatch: expected digit %h seg %h scan %0d,",
							$time, want.digit, want.segs, want.scan);
						$display("%0t:   got digit %h seg %h scan %0d",
							$time, got.digit, got.segs, got.scan);
					end
				end
			end
			if (text.valid && text.ready) begin
				want = scan_tick({text.char_7, text.char_6, text.char_5, text.char_4,
					text.char_3, text.char_2, text.char_1, text.char_0},
					scan_pos, dot_count, cathode, scan_nx, dots_nx);
				expected_drives.push_back(want);
				scan_pos  = scan_nx;
				dot_count = dots_nx;
			end
			if (psel && penable && pready && paddr[2] == REG_CATHODE_MODE) begin
				if (pwrite) begin
					cathode = pwdata[0];
				end else if (prdata !== APB_DATA_W'(cathode)) begin
					errors++;
					$display("%0t: cathode_mode read: expected %h got %h",
						$time, APB_DATA_W'(cathode), prdata);
				end
			end
			pending  <= expected_drives.size();
			checked  <= results;
			failures <= errors;
		end
	end

endmodule

// ----- tb/seven_segment_scan_decoder_test.sv -----
// Stimulus, flow control and verdict for the seven-segment scan decoder testbench.
module seven_segment_scan_decoder_test
	import sssd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [CHAR_COUNT-1:0][7:0] text_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int SWEEPS         = 20;
	localparam logic [APB_ADDR_W-1:0] CC_ADDR     = {REG_CATHODE_MODE, 2'b00};
	localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = {~REG_CATHODE_MODE, 2'b00};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int pending;
	int checked;
	int failures;
	int texts_sent;
	int gap_pct;
	int stall_pct;
	int idle_cycles;

	sssd_text_if  text_ch ();
	sssd_drive_if drive_ch ();

	seven_segment_scan_decoder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.drive   (drive_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	sssd_drive_checker drive_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text_ch),
		.drive    (drive_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.pending  (pending),
		.checked  (checked),
		.failures (failures)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n)
			drive_ch.ready <= 1'b0;
		else
			drive_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Abort when no transfer of any kind happens for too long
	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (drive_ch.valid && drive_ch.ready) ||
				(psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[seven_segment_scan_decoder] ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] glyph_char();
		case ($urandom_range(14))
			10:      return CHAR_C;
			11:      return CHAR_F;
			12:      return CHAR_A;
			13:      return CHAR_H;
			14:      return CHAR_DASH;
			default: return CHAR_ZERO + 8'($urandom_range(9));
		endcase
	endfunction

	function automatic text_t random_text();
		text_t t;
		int    i;
		int    kind;
		int    pick;
		t    = '0;
		kind = $urandom_range(9);
		if (kind <= 5) begin
			// readable text: glyphs, each maybe followed by a point
			i = 0;
			while (i < CHAR_COUNT) begin
				t[i] = glyph_char();
				i++;
				if (i < CHAR_COUNT && $urandom_range(2) == 0) begin
					t[i] = CHAR_DOT;
					i++;
				end
			end
		end else begin
			for (i = 0; i < CHAR_COUNT; i++) begin
				pick = $urandom_range(9);
				if (kind == 8)
					t[i] = 8'($urandom_range(255));
				else if (pick < 3)
					t[i] = CHAR_DOT;
				else if (kind == 9 && pick >= 7)
					t[i] = 8'($urandom_range(255));
				else
					t[i] = glyph_char();
			end
		end
		return t;
	endfunction

	task automatic send_text(input text_t t);
		if ($urandom_range(99) < gap_pct) begin
			text_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		text_ch.valid  <= 1'b1;
		text_ch.char_0 <= t[0];
		text_ch.char_1 <= t[1];
		text_ch.char_2 <= t[2];
		text_ch.char_3 <= t[3];
		text_ch.char_4 <= t[4];
		text_ch.char_5 <= t[5];
		text_ch.char_6 <= t[6];
		text_ch.char_7 <= t[7];
		do @(posedge clk); while (!text_ch.ready);
		texts_sent++;
	endtask

	task automatic reg_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Drain the pipeline so that a register write lands while idle
	task automatic settle();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic run_sweeps(input int count);
		text_t t;
		for (int s = 0; s < count; s++) begin
			t = random_text();
			for (int k = 0; k < DIGIT_COUNT; k++) begin
				if (k > 0 && $urandom_range(3) == 0)
					t = random_text();
				send_text(t);
			end
		end
	endtask

	initial begin
		text_t directed [5];
		logic  cc_val;
		arst_n         = 1'b0;
		text_ch.valid  = 1'b0;
		text_ch.char_0 = '0;
		text_ch.char_1 = '0;
		text_ch.char_2 = '0;
		text_ch.char_3 = '0;
		text_ch.char_4 = '0;
		text_ch.char_5 = '0;
		text_ch.char_6 = '0;
		text_ch.char_7 = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		gap_pct        = 0;
		stall_pct      = 0;
		texts_sent     = 0;

		// byte 0 is the first character, so the strings read right to left
		directed[0] = "76543210";
		directed[1] = ".7.6.5.4";
		directed[2] = ".-hafc98";
		directed[3] = {8'h00, CHAR_DOT, CHAR_DOT, 8'hFF, CHAR_DASH, CHAR_H, CHAR_DOT, CHAR_A};
		directed[4] = {CHAR_DOT, 8'h3A, 8'h2F, 8'hFF, CHAR_DOT, 8'h00, CHAR_DOT, CHAR_DOT};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_access(1'b0, CC_ADDR, '0);
		// hold each text for a whole sweep
		foreach (directed[d])
			for (int k = 0; k < DIGIT_COUNT; k++)
				send_text(directed[d]);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 85; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 85; end
				default: begin gap_pct = 6; stall_pct = 6; end
			endcase
			cc_val = p[0];
			reg_access(1'b1, CC_ADDR, {31'($urandom), cc_val});
			if (p == 2)
				reg_access(1'b1, UNUSED_ADDR, $urandom);
			reg_access(1'b0, CC_ADDR, '0);
			run_sweeps(SWEEPS);
			settle();
		end

		$display("Sent %0d texts, checked %0d scan ticks over both electrode polarities",
			texts_sent, checked);
		$display("and four flow-control mixes, with register writes between phases.");
		if (failures == 0)
			$display("[seven_segment_scan_decoder] OK");
		else
			$display("[seven_segment_scan_decoder] ERROR");
		$finish;
	end

endmodule
